### src/nfa_pkg.sv
// Shared types, constants and command codes of the next-fit free-list allocator.
`default_nettype none

package nfa_pkg;

    // Heap geometry.
    localparam int HEAP_UNITS = 16384;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int AW         = 14;
    localparam int SW         = 15;
    localparam int BW         = 18;
    localparam int STW        = 16;
    localparam int WALK_LIMIT = 2 * HEAP_UNITS + 8;

    typedef logic [AW-1:0] t_idx;
    typedef logic [SW-1:0] t_size;

    // Request kinds.
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Result status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_TOO_LARGE = 2'd1;
    localparam logic [1:0] ST_NO_HEAP   = 2'd2;
    localparam logic [1:0] ST_FREE_REJ  = 2'd3;

    // Register selects on the configuration port.
    localparam logic REG_MAX_REQ = 1'b0;
    localparam logic REG_GROW    = 1'b1;

    typedef struct packed {
        logic [BW-1:0] max_req;
        logic [AW-1:0] grow_units;
    } t_cfg;

    // Commands from the controller to the datapath.
    typedef enum logic [4:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_F_READ,
        CMD_SET_ERR1,
        CMD_SET_ERR2,
        CMD_SET_ERR3,
        CMD_SET_OK,
        CMD_A_INIT,
        CMD_A_ROVER,
        CMD_A_FIRST,
        CMD_A_EXACT,
        CMD_A_SPLIT,
        CMD_A_TAIL,
        CMD_A_NEXT,
        CMD_A_STEP,
        CMD_G_START,
        CMD_F_START,
        CMD_R_READ,
        CMD_R_STOP,
        CMD_R_NEXT,
        CMD_R_HI_READ,
        CMD_R_HI_LINK,
        CMD_R_HI_MERGE,
        CMD_R_LO_READ,
        CMD_R_LO_KEEP,
        CMD_R_LO_LINK,
        CMD_R_LO_MERGE,
        CMD_PUSH
    } t_cmd;

    // Status flags from the datapath to the controller.
    typedef struct packed {
        logic op_free;
        logic too_large;
        logic sz_eq_n;
        logic sz_ge_n;
        logic p_is_rover;
        logic steps_over;
        logic grow_fail;
        logic bsz_bad;
        logic walk_stop;
        logic rsteps_over;
        logic merge_hi;
        logic merge_lo;
        logic from_grow;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

### src/next_fit_free_list_allocator.sv
// Top level of the next-fit free-list heap allocator.
//
// Requests arrive on the s_axis channel: s_axis_tuser selects allocate (0) or
// free (1), s_axis_tdata carries the byte count and the data unit index. Each
// request yields exactly one transfer on m_axis with the granted data index
// and a status code. Requests are handled one at a time; s_axis_tready is
// high only while the sequencer is idle.
// An allocate walks the free list from the rover; when no block fits, it grows
// the heap and walks the list again to insert the new block. A free walks the
// list to find the place of the freed block and merges it with its neighbours.
// Reset (synchronous, active low) empties the heap: the rover points at the
// sentinel, the break is at unit one, and the registers return to their
// defaults. Header memory is not cleared; headers are written before use.
// A finished result sits in the output register; while the receiver stalls the
// block still accepts one new request and holds its result until the output
// register frees up. Configuration is written through the APB-style port.
`default_nettype none

module next_fit_free_list_allocator (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // [17:0] request_bytes, [31:18] block_address
    input  wire logic [31:0]  s_axis_tdata,
    // [0] opcode
    input  wire logic         s_axis_tuser,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    // [13:0] data_address, [15:14] status
    output logic [15:0]       m_axis_tdata,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    import nfa_pkg::*;

    t_cfg       w_cfg;
    t_cmd       w_cmd;
    t_dp_status w_status;
    t_idx       w_out_addr;
    logic [1:0] w_out_status;

    nfa_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    nfa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    nfa_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_cfg        (w_cfg),
        .i_op         (s_axis_tuser),
        .i_bytes      (s_axis_tdata[BW-1:0]),
        .i_blk        (s_axis_tdata[BW+AW-1:BW]),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_out_addr   (w_out_addr),
        .o_out_status (w_out_status),
        .o_status     (w_status)
    );

    assign m_axis_tdata = {w_out_status, w_out_addr};

endmodule

`default_nettype wire

### src/nfa_regs.sv
// Configuration registers behind the APB-style port.
`default_nettype none

module nfa_regs (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [2:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output nfa_pkg::t_cfg     o_cfg
);
    import nfa_pkg::*;

    logic [BW-1:0] r_max_req;
    logic [AW-1:0] r_grow;
    logic          w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes complete in the access cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_req <= BW'(10240);
            r_grow    <= AW'(1024);
        end else if (w_wr) begin
            if (paddr[2] == REG_MAX_REQ) begin
                r_max_req <= pwdata[BW-1:0];
            end else begin
                r_grow <= pwdata[AW-1:0];
            end
        end
    end

    // Read back the selected register.
    always_comb begin
        if (paddr[2] == REG_GROW) begin
            prdata = 32'(r_grow);
        end else begin
            prdata = 32'(r_max_req);
        end
    end

    assign o_cfg.max_req    = r_max_req;
    assign o_cfg.grow_units = r_grow;

endmodule

`default_nettype wire

### src/nfa_datapath.sv
// Header memories, list pointers, arithmetic and result register of the allocator.
`default_nettype none

module nfa_datapath (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  nfa_pkg::t_cmd             i_cmd,
    input  nfa_pkg::t_cfg             i_cfg,
    input  wire logic                 i_op,
    input  wire logic [17:0]          i_bytes,
    input  wire logic [13:0]          i_blk,
    input  wire logic                 i_out_ready,
    output logic                      o_out_valid,
    output logic [13:0]               o_out_addr,
    output logic [1:0]                o_out_status,
    output nfa_pkg::t_dp_status       o_status
);
    import nfa_pkg::*;

    // Header store split into next and size fields.
    t_idx  r_next_mem [HEAP_UNITS];
    t_size r_size_mem [HEAP_UNITS];
    t_idx  r_rd_next;
    t_size r_rd_size;

    // Control state.
    t_idx  r_rover;
    logic [SW-1:0] r_brk;
    t_size r_largest;
    logic  r_started;
    logic  r_from_grow;
    logic  r_out_valid;

    // Working registers.
    logic          r_op;
    logic [BW-1:0] r_bytes;
    t_idx          r_blk;
    t_size         r_n;
    t_idx          r_p;
    t_idx          r_prev;
    t_idx          r_bp;
    t_size         r_bsz;
    t_idx          r_nx;
    t_size         r_tmp;
    logic [STW-1:0] r_steps;
    logic [STW-1:0] r_rsteps;
    t_idx          r_res_addr;
    logic [1:0]    r_res_status;
    t_idx          r_out_addr;
    logic [1:0]    r_out_status;

    logic [BW:0]   w_round;
    t_size         w_n;
    t_size         w_grow;
    t_size         w_nu;
    t_size         w_rem;
    t_idx          w_raddr;
    logic          w_we_next;
    logic          w_we_size;
    t_idx          w_waddr;
    t_idx          w_wnext;
    t_size         w_wsize;

    // Request size in units, one header included.
    assign w_round = {1'b0, r_bytes} + (BW+1)'(UNIT_BYTES - 1);
    assign w_n     = t_size'(w_round >> UNIT_SHIFT) + t_size'(1);
    assign w_grow  = t_size'(i_cfg.grow_units);
    assign w_nu    = (r_n < w_grow) ? w_grow : r_n;
    assign w_rem   = r_rd_size - r_n;

    // Status toward the controller.
    assign o_status.op_free     = (r_op == OP_FREE);
    assign o_status.too_large   = (r_bytes > i_cfg.max_req);
    assign o_status.sz_eq_n     = (r_rd_size == r_n);
    assign o_status.sz_ge_n     = (r_rd_size >= r_n);
    assign o_status.p_is_rover  = (r_p == r_rover);
    assign o_status.steps_over  = (r_steps >= STW'(WALK_LIMIT));
    assign o_status.grow_fail   = ((STW'(r_brk) + STW'(w_nu)) > STW'(HEAP_UNITS));
    assign o_status.bsz_bad     = (r_rd_size == '0) || (r_rd_size > r_largest);
    assign o_status.walk_stop   = ((r_bp > r_p) && (r_bp < r_rd_next)) ||
                                  ((r_p >= r_rd_next) && ((r_bp > r_p) || (r_bp < r_rd_next)));
    assign o_status.rsteps_over = (r_rsteps >= STW'(WALK_LIMIT));
    assign o_status.merge_hi    = ((STW'(r_bp) + STW'(r_bsz)) == STW'(r_nx));
    assign o_status.merge_lo    = ((STW'(r_p) + STW'(r_rd_size)) == STW'(r_bp));
    assign o_status.from_grow   = r_from_grow;
    assign o_status.out_free    = !r_out_valid || i_out_ready;

    // Read address for the header fetch of the next cycle.
    always_comb begin
        unique case (i_cmd)
            CMD_F_READ:    w_raddr = r_blk - t_idx'(1);
            CMD_A_ROVER:   w_raddr = r_rover;
            CMD_A_FIRST,
            CMD_A_NEXT,
            CMD_R_NEXT:    w_raddr = r_rd_next;
            CMD_R_HI_READ: w_raddr = r_nx;
            CMD_R_LO_KEEP: w_raddr = r_bp;
            default:       w_raddr = r_p;
        endcase
    end

    // Header write port.
    always_comb begin
        w_we_next = 1'b0;
        w_we_size = 1'b0;
        w_waddr   = r_p;
        w_wnext   = r_rd_next;
        w_wsize   = r_n;
        unique case (i_cmd)
            CMD_A_INIT: begin
                w_we_next = !r_started;
                w_we_size = !r_started;
                w_waddr   = '0;
                w_wnext   = '0;
                w_wsize   = '0;
            end
            CMD_A_EXACT: begin
                w_we_next = 1'b1;
                w_waddr   = r_prev;
            end
            CMD_A_SPLIT: begin
                w_we_size = 1'b1;
                w_wsize   = w_rem;
            end
            CMD_A_TAIL: begin
                w_we_size = 1'b1;
            end
            CMD_G_START: begin
                w_we_size = 1'b1;
                w_waddr   = r_brk[AW-1:0];
                w_wsize   = w_nu;
            end
            CMD_R_HI_LINK: begin
                w_we_next = 1'b1;
                w_waddr   = r_bp;
                w_wnext   = r_nx;
            end
            CMD_R_HI_MERGE: begin
                w_we_next = 1'b1;
                w_we_size = 1'b1;
                w_waddr   = r_bp;
                w_wsize   = r_bsz + r_rd_size;
            end
            CMD_R_LO_LINK: begin
                w_we_next = 1'b1;
                w_wnext   = r_bp;
            end
            CMD_R_LO_MERGE: begin
                w_we_next = 1'b1;
                w_we_size = 1'b1;
                w_wsize   = r_tmp + r_rd_size;
            end
            default: begin
            end
        endcase
    end

    // Header memories with registered read data.
    always_ff @(posedge i_clk) begin
        if (w_we_next) begin
            r_next_mem[w_waddr] <= w_wnext;
        end
        if (w_we_size) begin
            r_size_mem[w_waddr] <= w_wsize;
        end
        r_rd_next <= r_next_mem[w_raddr];
        r_rd_size <= r_size_mem[w_raddr];
    end

    // Heap bookkeeping and the output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rover     <= '0;
            r_brk       <= SW'(1);
            r_largest   <= '0;
            r_started   <= 1'b0;
            r_from_grow <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result takes the output register; otherwise a transfer empties it.
            if (i_cmd == CMD_PUSH) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (i_cmd)
                CMD_A_INIT: begin
                    if (!r_started) begin
                        r_rover   <= '0;
                        r_started <= 1'b1;
                    end
                end
                CMD_A_EXACT,
                CMD_A_SPLIT: r_rover <= r_prev;
                CMD_G_START: begin
                    r_brk       <= r_brk + w_nu;
                    r_from_grow <= 1'b1;
                    if (w_nu > r_largest) begin
                        r_largest <= w_nu;
                    end
                end
                CMD_F_START: r_from_grow <= 1'b0;
                CMD_R_LO_LINK,
                CMD_R_LO_MERGE: r_rover <= r_p;
                default: begin
                end
            endcase
        end
    end

    // Working registers and the result.
    always_ff @(posedge i_clk) begin
        unique case (i_cmd)
            CMD_LOAD: begin
                r_op    <= i_op;
                r_bytes <= i_bytes;
                r_blk   <= i_blk;
            end
            CMD_F_READ: r_bp <= r_blk - t_idx'(1);
            CMD_SET_ERR1: begin
                r_res_addr   <= '0;
                r_res_status <= ST_TOO_LARGE;
            end
            CMD_SET_ERR2: begin
                r_res_addr   <= '0;
                r_res_status <= ST_NO_HEAP;
            end
            CMD_SET_ERR3: begin
                r_res_addr   <= '0;
                r_res_status <= ST_FREE_REJ;
            end
            CMD_SET_OK: begin
                r_res_addr   <= '0;
                r_res_status <= ST_OK;
            end
            CMD_A_INIT: begin
                r_n     <= w_n;
                r_steps <= '0;
            end
            CMD_A_ROVER: r_prev <= r_rover;
            CMD_A_FIRST: r_p <= r_rd_next;
            CMD_A_EXACT: begin
                r_res_addr   <= r_p + t_idx'(1);
                r_res_status <= ST_OK;
            end
            CMD_A_SPLIT: r_p <= r_p + w_rem[AW-1:0];
            CMD_A_TAIL: begin
                r_res_addr   <= r_p + t_idx'(1);
                r_res_status <= ST_OK;
            end
            CMD_A_NEXT: begin
                r_steps <= r_steps + STW'(1);
                r_prev  <= r_p;
                r_p     <= r_rd_next;
            end
            CMD_A_STEP: r_steps <= r_steps + STW'(1);
            CMD_G_START: begin
                r_bp     <= r_brk[AW-1:0];
                r_bsz    <= w_nu;
                r_p      <= r_rover;
                r_rsteps <= '0;
            end
            CMD_F_START: begin
                r_bsz    <= r_rd_size;
                r_p      <= r_rover;
                r_rsteps <= '0;
            end
            CMD_R_STOP: r_nx <= r_rd_next;
            CMD_R_NEXT: begin
                r_rsteps <= r_rsteps + STW'(1);
                r_p      <= r_rd_next;
            end
            CMD_R_LO_KEEP: r_tmp <= r_rd_size;
            CMD_PUSH: begin
                r_out_addr   <= r_res_addr;
                r_out_status <= r_res_status;
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_addr   = r_out_addr;
    assign o_out_status = r_out_status;

endmodule

`default_nettype wire

### src/nfa_ctrl.sv
// Sequencer that walks the free list and drives the datapath commands.
`default_nettype none

module nfa_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  nfa_pkg::t_dp_status       i_status,
    output nfa_pkg::t_cmd             o_cmd
);
    import nfa_pkg::*;

    typedef enum logic [16:0] {
        S_IDLE      = 17'h00001,
        S_DECODE    = 17'h00002,
        S_A_ROVER   = 17'h00004,
        S_A_FIRST   = 17'h00008,
        S_A_SCAN    = 17'h00010,
        S_A_TAIL    = 17'h00020,
        S_F_CHECK   = 17'h00040,
        S_R_READ    = 17'h00080,
        S_R_WALK    = 17'h00100,
        S_R_HI      = 17'h00200,
        S_R_HI_WR   = 17'h00400,
        S_R_LO_READ = 17'h00800,
        S_R_LO      = 17'h01000,
        S_R_LO_WR   = 17'h02000,
        S_R_END     = 17'h04000,
        S_G_CONT    = 17'h08000,
        S_DONE      = 17'h10000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_in_ready = (r_state == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and command.
    always_comb begin
        n_state = r_state;
        o_cmd   = CMD_NONE;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd   = CMD_LOAD;
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                priority if (i_status.op_free) begin
                    o_cmd   = CMD_F_READ;
                    n_state = S_F_CHECK;
                end else if (i_status.too_large) begin
                    o_cmd   = CMD_SET_ERR1;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_A_INIT;
                    n_state = S_A_ROVER;
                end
            end
            S_A_ROVER: begin
                o_cmd   = CMD_A_ROVER;
                n_state = S_A_FIRST;
            end
            S_A_FIRST: begin
                o_cmd   = CMD_A_FIRST;
                n_state = S_A_SCAN;
            end
            S_A_SCAN: begin
                priority if (i_status.sz_eq_n) begin
                    o_cmd   = CMD_A_EXACT;
                    n_state = S_DONE;
                end else if (i_status.sz_ge_n) begin
                    o_cmd   = CMD_A_SPLIT;
                    n_state = S_A_TAIL;
                end else if (i_status.p_is_rover) begin
                    if (i_status.grow_fail) begin
                        o_cmd   = CMD_SET_ERR2;
                        n_state = S_DONE;
                    end else begin
                        o_cmd   = CMD_G_START;
                        n_state = S_R_READ;
                    end
                end else if (i_status.steps_over) begin
                    o_cmd   = CMD_SET_ERR2;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_A_NEXT;
                end
            end
            S_A_TAIL: begin
                o_cmd   = CMD_A_TAIL;
                n_state = S_DONE;
            end
            S_F_CHECK: begin
                if (i_status.bsz_bad) begin
                    o_cmd   = CMD_SET_ERR3;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_F_START;
                    n_state = S_R_READ;
                end
            end
            S_R_READ: begin
                o_cmd   = CMD_R_READ;
                n_state = S_R_WALK;
            end
            S_R_WALK: begin
                priority if (i_status.walk_stop) begin
                    o_cmd   = CMD_R_STOP;
                    n_state = S_R_HI;
                end else if (i_status.rsteps_over) begin
                    if (i_status.from_grow) begin
                        n_state = S_G_CONT;
                    end else begin
                        o_cmd   = CMD_SET_ERR3;
                        n_state = S_DONE;
                    end
                end else begin
                    o_cmd   = CMD_R_NEXT;
                end
            end
            S_R_HI: begin
                if (i_status.merge_hi) begin
                    o_cmd   = CMD_R_HI_READ;
                    n_state = S_R_HI_WR;
                end else begin
                    o_cmd   = CMD_R_HI_LINK;
                    n_state = S_R_LO_READ;
                end
            end
            S_R_HI_WR: begin
                o_cmd   = CMD_R_HI_MERGE;
                n_state = S_R_LO_READ;
            end
            S_R_LO_READ: begin
                o_cmd   = CMD_R_LO_READ;
                n_state = S_R_LO;
            end
            S_R_LO: begin
                if (i_status.merge_lo) begin
                    o_cmd   = CMD_R_LO_KEEP;
                    n_state = S_R_LO_WR;
                end else begin
                    o_cmd   = CMD_R_LO_LINK;
                    n_state = S_R_END;
                end
            end
            S_R_LO_WR: begin
                o_cmd   = CMD_R_LO_MERGE;
                n_state = S_R_END;
            end
            S_R_END: begin
                if (i_status.from_grow) begin
                    n_state = S_G_CONT;
                end else begin
                    o_cmd   = CMD_SET_OK;
                    n_state = S_DONE;
                end
            end
            S_G_CONT: begin
                if (i_status.steps_over) begin
                    o_cmd   = CMD_SET_ERR2;
                    n_state = S_DONE;
                end else begin
                    o_cmd   = CMD_A_STEP;
                    n_state = S_A_ROVER;
                end
            end
            S_DONE: begin
                if (i_status.out_free) begin
                    o_cmd   = CMD_PUSH;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### src/nfa_checker.sv
// Port-level checks of the allocator and their attachment to the top level.
`default_nettype none

module nfa_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        s_axis_tvalid,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata
);
    import nfa_pkg::*;

    // A result waiting on a stalled receiver stays offered.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // A rejected request never carries a granted address.
    a_err_no_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[15:14] != ST_OK) |-> (m_axis_tdata[13:0] == 14'd0))
        else $error("error result with nonzero address");

    // Requests are served one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second request taken while busy");

    // A request transfer cannot complete a result in the next cycle.
    a_no_instant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> !m_axis_tvalid)
        else $error("result appeared too early");

endmodule

bind next_fit_free_list_allocator nfa_checker u_nfa_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
